FILE: hdl/cordic_sine_cosine_macros.svh
// Assertion macros shared by the checker of cordic_sine_cosine.
// Depends on nothing; the using scope supplies clk and rst_n.
`ifndef CORDIC_SINE_COSINE_MACROS_SVH
`define CORDIC_SINE_COSINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Implication with a fixed delay in cycles, disabled during reset.
`define CSC_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

FILE: hdl/cordic_sc_pkg.sv
// Types, constants and the arctangent table for the CORDIC sine/cosine block.
// Depends on nothing; used by cordic_sc_step and cordic_sine_cosine.
package cordic_sc_pkg;

    localparam int STEPS_DEF = 61;
    localparam int WORD_W    = 64;
    localparam int PHASE_W   = 62;
    localparam int FRAC_W    = 60;
    localparam int ROM_IDX_W = 6;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } cordic_vec_t;

    localparam word_t START_X = 64'sh26DD3B6A10D79A00;

    function automatic word_t atan_rom(input logic [ROM_IDX_W-1:0] idx);
        word_t val;
        case (idx)
            6'd0:    val = 64'sh0800000000000000;
            6'd1:    val = 64'sh04B90147677CC200;
            6'd2:    val = 64'sh027ECE16D7B8E7A0;
            6'd3:    val = 64'sh0144447507776690;
            6'd4:    val = 64'sh00A2C350C39626C0;
            6'd5:    val = 64'sh005175F8564118A0;
            6'd6:    val = 64'sh0028BD87970A098C;
            6'd7:    val = 64'sh00145F15447510AC;
            6'd8:    val = 64'sh000A2F94D1B430CE;
            6'd9:    val = 64'sh000517CBAECC2ACE;
            6'd10:   val = 64'sh00028BE600246E9E;
            6'd11:   val = 64'sh000145F3052A032D;
            6'd12:   val = 64'sh0000A2F98337FB18;
            6'd13:   val = 64'sh0000517CC1B05CBC;
            6'd14:   val = 64'sh000028BE60DABA44;
            6'd15:   val = 64'sh0000145F306DAE9E;
            6'd16:   val = 64'sh00000A2F9836E17F;
            6'd17:   val = 64'sh00000517CC1B7205;
            6'd18:   val = 64'sh0000028BE60DB92B;
            6'd19:   val = 64'sh00000145F306DC9A;
            6'd20:   val = 64'sh000000A2F9836E4E;
            6'd21:   val = 64'sh000000517CC1B727;
            6'd22:   val = 64'sh00000028BE60DB93;
            6'd23:   val = 64'sh000000145F306DC9;
            6'd24:   val = 64'sh0000000A2F9836E4;
            6'd25:   val = 64'sh0000000517CC1B72;
            6'd26:   val = 64'sh000000028BE60DB9;
            6'd27:   val = 64'sh0000000145F306DC;
            6'd28:   val = 64'sh00000000A2F9836E;
            6'd29:   val = 64'sh00000000517CC1B7;
            6'd30:   val = 64'sh0000000028BE60DB;
            6'd31:   val = 64'sh00000000145F306D;
            6'd32:   val = 64'sh000000000A2F9836;
            6'd33:   val = 64'sh000000000517CC1B;
            6'd34:   val = 64'sh00000000028BE60D;
            6'd35:   val = 64'sh000000000145F306;
            6'd36:   val = 64'sh0000000000A2F983;
            6'd37:   val = 64'sh0000000000517CC1;
            6'd38:   val = 64'sh000000000028BE60;
            6'd39:   val = 64'sh0000000000145F30;
            6'd40:   val = 64'sh00000000000A2F98;
            6'd41:   val = 64'sh00000000000517CC;
            6'd42:   val = 64'sh0000000000028BE6;
            6'd43:   val = 64'sh00000000000145F3;
            6'd44:   val = 64'sh000000000000A2F9;
            6'd45:   val = 64'sh000000000000517C;
            6'd46:   val = 64'sh00000000000028BE;
            6'd47:   val = 64'sh000000000000145F;
            6'd48:   val = 64'sh0000000000000A2F;
            6'd49:   val = 64'sh0000000000000517;
            6'd50:   val = 64'sh000000000000028B;
            6'd51:   val = 64'sh0000000000000145;
            6'd52:   val = 64'sh00000000000000A2;
            6'd53:   val = 64'sh0000000000000051;
            6'd54:   val = 64'sh0000000000000028;
            6'd55:   val = 64'sh0000000000000014;
            6'd56:   val = 64'sh000000000000000A;
            6'd57:   val = 64'sh0000000000000005;
            6'd58:   val = 64'sh0000000000000002;
            6'd59:   val = 64'sh0000000000000001;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/cordic_sine_cosine.sv
// Top level of the iterative CORDIC sine/cosine generator.
// Depends on cordic_sc_pkg and cordic_sc_step.
//
// Usage:
//   Drive phase and raise start while busy is low; that edge accepts the
//   transaction. phase[61:60] is the quadrant, phase[59:0] the angle within
//   it (2^60 = quarter turn).
//   busy stays high while the angle is rotated: one CORDIC step per cycle on
//   the single shift/add unit, STEPS steps in all, then the quadrant fixup.
//   done pulses for exactly one cycle with sine and cosine (2^62 = 1.0);
//   the receiver must take them in that cycle, it cannot stall the block.
//   The accepting edge loads the vector, ST_RUN performs the rotation steps
//   and ST_FINISH applies the quadrant fixup, registering sine, cosine and
//   done. busy is already low while done is high, so a new transaction may
//   start alongside.
//   Reset clears the sequencer and done; sine and cosine are not reset.
module cordic_sine_cosine
    import cordic_sc_pkg::*;
#(
    parameter int STEPS = STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [PHASE_W-1:0]       phase,
    output logic                     done,
    output logic signed [WORD_W-1:0] sine,
    output logic signed [WORD_W-1:0] cosine
);

    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]  quad_reg, quad_next;
    cordic_vec_t vec_reg, vec_next;
    cordic_vec_t step_out;
    logic        done_reg, done_next;
    word_t       sine_reg, sine_next;
    word_t       cosine_reg, cosine_next;
    word_t       s_pre;
    word_t       c_pre;
    logic        accept;

    assign accept = start && (state_reg == ST_IDLE);

    cordic_sc_step u_step (
        .cur (vec_reg),
        .idx (ROM_IDX_W'(cnt_reg)),
        .nxt (step_out)
    );

    always_comb
    begin
        s_pre = quad_reg[0] ? vec_reg.x : vec_reg.y;
        c_pre = quad_reg[0] ? vec_reg.y : vec_reg.x;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        quad_next   = quad_reg;
        vec_next    = vec_reg;
        done_next   = 1'b0;
        sine_next   = sine_reg;
        cosine_next = cosine_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    quad_next  = phase[PHASE_W-1:FRAC_W];
                    vec_next.x = START_X;
                    vec_next.y = '0;
                    vec_next.z = word_t'({{(WORD_W-FRAC_W){1'b0}}, phase[FRAC_W-1:0]});
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                vec_next = step_out;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // negate sine in the lower half-turn, cosine in the left half-plane
                sine_next   = quad_reg[1] ? -s_pre : s_pre;
                cosine_next = (quad_reg[1] ^ quad_reg[0]) ? -c_pre : c_pre;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg   <= quad_next;
        vec_reg    <= vec_next;
        sine_reg   <= sine_next;
        cosine_reg <= cosine_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

FILE: hdl/cordic_sc_step.sv
// One rotation-mode CORDIC step: two arithmetic shifters and three add/subtract units.
// Depends on cordic_sc_pkg for the vector type and the arctangent table.
module cordic_sc_step
    import cordic_sc_pkg::*;
(
    input  cordic_vec_t              cur,
    input  logic [ROM_IDX_W-1:0]     idx,
    output cordic_vec_t              nxt
);

    logic  neg;
    word_t xs;
    word_t ys;
    word_t ang;

    assign neg = cur.z[WORD_W-1];
    assign xs  = cur.x >>> idx;
    assign ys  = cur.y >>> idx;
    assign ang = atan_rom(idx);

    // rotate toward zero residual angle; zero counts as non-negative
    assign nxt.x = neg ? (cur.x + ys)  : (cur.x - ys);
    assign nxt.y = neg ? (cur.y - xs)  : (cur.y + xs);
    assign nxt.z = neg ? (cur.z + ang) : (cur.z - ang);

endmodule

FILE: hdl/cordic_sc_chk.sv
// Port-level checker for cordic_sine_cosine, bound to the top level.
// Depends on cordic_sine_cosine_macros.svh and cordic_sc_pkg.
`include "cordic_sine_cosine_macros.svh"

module cordic_sc_chk
    import cordic_sc_pkg::*;
#(
    parameter int STEPS = STEPS_DEF
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    `CSC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `CSC_ASSERT_DELAY(a_latency, start && !busy, STEPS + 2, done, "result not delivered on time")
    `CSC_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
    `CSC_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `CSC_ASSERT_NOW(a_fall_done, $fell(busy), done, "busy dropped without a result")

endmodule

bind cordic_sine_cosine cordic_sc_chk #(.STEPS(STEPS)) u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

FILE: dv/tb_cordic_sine_cosine.sv
`timescale 1ns / 100ps
// Self-checking testbench for cordic_sine_cosine: drives phase angles and checks
// every sine/cosine result against a bit-exact rotation-mode CORDIC predictor.
// Depends on cordic_sc_pkg and the cordic_sine_cosine RTL.
module tb_cordic_sine_cosine;
    import cordic_sc_pkg::*;

    localparam int ROTATIONS     = STEPS_DEF;
    localparam int RANDOM_ANGLES = 1950;
    localparam int SETTLE_EVERY  = 150;
    localparam int MAX_GAP       = 90;
    localparam int MAX_BURST     = 12;
    localparam int STALL_LIMIT   = 4000;

    localparam word_t START_VEC = 64'sh26DD3B6A10D79A00;

    localparam word_t ATAN_TBL [64] = '{
        64'sh0800000000000000, 64'sh04B90147677CC200, 64'sh027ECE16D7B8E7A0,
        64'sh0144447507776690, 64'sh00A2C350C39626C0, 64'sh005175F8564118A0,
        64'sh0028BD87970A098C, 64'sh00145F15447510AC, 64'sh000A2F94D1B430CE,
        64'sh000517CBAECC2ACE, 64'sh00028BE600246E9E, 64'sh000145F3052A032D,
        64'sh0000A2F98337FB18, 64'sh0000517CC1B05CBC, 64'sh000028BE60DABA44,
        64'sh0000145F306DAE9E, 64'sh00000A2F9836E17F, 64'sh00000517CC1B7205,
        64'sh0000028BE60DB92B, 64'sh00000145F306DC9A, 64'sh000000A2F9836E4E,
        64'sh000000517CC1B727, 64'sh00000028BE60DB93, 64'sh000000145F306DC9,
        64'sh0000000A2F9836E4, 64'sh0000000517CC1B72, 64'sh000000028BE60DB9,
        64'sh0000000145F306DC, 64'sh00000000A2F9836E, 64'sh00000000517CC1B7,
        64'sh0000000028BE60DB, 64'sh00000000145F306D, 64'sh000000000A2F9836,
        64'sh000000000517CC1B, 64'sh00000000028BE60D, 64'sh000000000145F306,
        64'sh0000000000A2F983, 64'sh0000000000517CC1, 64'sh000000000028BE60,
        64'sh0000000000145F30, 64'sh00000000000A2F98, 64'sh00000000000517CC,
        64'sh0000000000028BE6, 64'sh00000000000145F3, 64'sh000000000000A2F9,
        64'sh000000000000517C, 64'sh00000000000028BE, 64'sh000000000000145F,
        64'sh0000000000000A2F, 64'sh0000000000000517, 64'sh000000000000028B,
        64'sh0000000000000145, 64'sh00000000000000A2, 64'sh0000000000000051,
        64'sh0000000000000028, 64'sh0000000000000014, 64'sh000000000000000A,
        64'sh0000000000000005, 64'sh0000000000000002, 64'sh0000000000000001,
        64'sh0000000000000000, 64'sh0000000000000000, 64'sh0000000000000000,
        64'sh0000000000000000
    };

    typedef struct {
        logic [PHASE_W-1:0] angle;
        bit                 settle;
    } angle_item_t;

    typedef struct {
        logic [PHASE_W-1:0] angle;
        word_t              sine;
        word_t              cosine;
    } sincos_t;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [PHASE_W-1:0] phase = '0;
    logic               busy;
    logic               done;
    word_t              sine;
    word_t              cosine;

    angle_item_t angle_queue[$];
    sincos_t     pending_sincos[$];
    int          err_count    = 0;
    int          stall_cycles = 0;
    int          burst_left   = 1;
    int          gap_left     = 0;

    cordic_sine_cosine #(.STEPS(ROTATIONS)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .phase  (phase),
        .done   (done),
        .sine   (sine),
        .cosine (cosine)
    );

    always #5 clk = ~clk;

    function automatic sincos_t rotate_angle(input logic [PHASE_W-1:0] ang);
        word_t      x;
        word_t      y;
        word_t      z;
        word_t      xs;
        word_t      ys;
        logic [1:0] quad;
        sincos_t    res;
        quad = ang[PHASE_W-1:FRAC_W];
        x = START_VEC;
        y = '0;
        z = word_t'({4'b0, ang[FRAC_W-1:0]});
        for (int i = 0; i < ROTATIONS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z[WORD_W-1])
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TBL[i % 64];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TBL[i % 64];
            end
        end
        res.angle  = ang;
        res.sine   = quad[0] ? x : y;
        res.cosine = quad[0] ? y : x;
        if (quad[1])
            res.sine = -res.sine;
        if (quad == 2'd1 || quad == 2'd2)
            res.cosine = -res.cosine;
        return res;
    endfunction

    function automatic logic [PHASE_W-1:0] pick_angle();
        logic [63:0] bits;
        word_t       acc;
        int          depth;
        bits = {$urandom, $urandom};
        acc = '0;
        depth = 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4: bits[FRAC_W-1:0] = FRAC_W'($urandom_range(0, 4095));
            5: bits[FRAC_W-1:0] = {FRAC_W{1'b1}} - FRAC_W'($urandom_range(0, 4095));
            6: bits[FRAC_W-1:0] = (60'd1 << 59) + FRAC_W'($urandom_range(0, 512)) - 60'd256;
            7:
            begin
                // walk the table so the residual lands on zero at a random step
                depth = $urandom_range(0, 59);
                for (int j = 0; j <= depth; j++)
                    acc = (j == 0 || $urandom_range(0, 1)) ? acc + ATAN_TBL[j]
                                                           : acc - ATAN_TBL[j];
                bits[FRAC_W-1:0] = acc[FRAC_W-1:0];
            end
            8: bits = bits & {$urandom, $urandom};
            default: bits = bits | {$urandom, $urandom};
        endcase
        return bits[PHASE_W-1:0];
    endfunction

    always @(posedge clk)
    begin : drive_blk
        angle_item_t nxt;
        bit          launched;
        if (rst_n)
        begin
            launched = start && !busy;
            if (launched)
            begin
                pending_sincos.push_back(rotate_angle(phase));
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, MAX_BURST);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
                end
            end
            if (start && !launched)
            begin
                // hold the transaction until busy drops
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (angle_queue.size() != 0
                     && !(angle_queue[0].settle && pending_sincos.size() != 0))
            begin
                nxt = angle_queue.pop_front();
                start <= 1'b1;
                phase <= nxt.angle;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_blk
        sincos_t want;
        if (rst_n && done)
        begin
            if (pending_sincos.size() == 0)
            begin
                $error("unexpected transaction: sine %h cosine %h", sine, cosine);
                err_count++;
            end
            else
            begin
                want = pending_sincos.pop_front();
                if (sine !== want.sine)
                begin
                    $error("phase %h: sine expected %h actual %h", want.angle, want.sine, sine);
                    err_count++;
                end
                if (cosine !== want.cosine)
                begin
                    $error("phase %h: cosine expected %h actual %h",
                           want.angle, want.cosine, cosine);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus_blk
        angle_item_t item;
        item.settle = 1'b0;
        for (int q = 0; q < 4; q++)
        begin
            item.angle = {q[1:0], 60'd0};
            angle_queue.push_back(item);
            item.angle = {q[1:0], 60'h800000000000000};
            angle_queue.push_back(item);
            item.angle = {q[1:0], {FRAC_W{1'b1}}};
            angle_queue.push_back(item);
        end
        item.angle = 62'd1;
        angle_queue.push_back(item);
        item.angle = {2'd0, 60'h800000000000000 + 60'h4B90147677CC200};
        angle_queue.push_back(item);
        item.angle = {2'd2, 60'h800000000000000 + 60'h4B90147677CC200};
        angle_queue.push_back(item);
        item.angle = 62'h2AAAAAAAAAAAAAAA;
        angle_queue.push_back(item);
        item.angle = 62'h1555555555555555;
        angle_queue.push_back(item);
        for (int n = 0; n < RANDOM_ANGLES; n++)
        begin
            item.angle  = pick_angle();
            item.settle = (n % SETTLE_EVERY) == 0;
            angle_queue.push_back(item);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (angle_queue.size() != 0 || start || pending_sincos.size() != 0)
            @(posedge clk);
        repeat (ROTATIONS + 8) @(posedge clk);

        if (err_count == 0 && pending_sincos.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
